### hw/rtl/ctt_pkg.sv
// Shared constants, types and function codes of the character set translation table.
package ctt_pkg;

    localparam int SET_SIZE = 256;
    localparam int REF_BITS = 16;
    localparam int IDX_W    = (SET_SIZE > 2) ? $clog2(SET_SIZE) : 1;
    localparam int BYTE_W   = 8;
    localparam int FUNC_W   = 3;
    localparam int REF_IN_W = 16;

    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [REF_BITS-1:0] t_ref;
    typedef logic [BYTE_W-1:0]   t_byte;

    localparam t_idx LAST_IDX = t_idx'(SET_SIZE - 1);

    typedef enum logic [FUNC_W-1:0] {
        FN_LD_SRC = 3'd0,
        FN_LD_REP = 3'd1,
        FN_LD_TGT = 3'd2,
        FN_BUILD  = 3'd3,
        FN_CONV   = 3'd4
    } t_func;

    // Write request into the three reference code tables.
    typedef struct packed {
        logic we_src;
        logic we_rep;
        logic we_tgt;
        t_idx addr;
        t_ref data;
    } t_ld_req;

    // Write request into the translation map.
    typedef struct packed {
        logic  we;
        t_idx  addr;
        t_byte data;
    } t_map_wr;

endpackage

### hw/rtl/ctt_ref_tables.sv
// Source, replacement and target reference code memories with one shared read address.
module ctt_ref_tables (
    input  logic             i_clk,
    input  ctt_pkg::t_ld_req i_ld,
    input  ctt_pkg::t_idx    i_rd_addr,
    output ctt_pkg::t_ref    o_src_q,
    output ctt_pkg::t_ref    o_rep_q,
    output ctt_pkg::t_ref    o_tgt_q
);
    import ctt_pkg::*;

    t_ref r_src_mem [SET_SIZE];
    t_ref r_rep_mem [SET_SIZE];
    t_ref r_tgt_mem [SET_SIZE];
    t_ref r_src_q;
    t_ref r_rep_q;
    t_ref r_tgt_q;

    always_ff @(posedge i_clk) begin
        if (i_ld.we_src) begin
            r_src_mem[i_ld.addr] <= i_ld.data;
        end
        if (i_ld.we_rep) begin
            r_rep_mem[i_ld.addr] <= i_ld.data;
        end
        if (i_ld.we_tgt) begin
            r_tgt_mem[i_ld.addr] <= i_ld.data;
        end
        r_src_q <= r_src_mem[i_rd_addr];
        r_rep_q <= r_rep_mem[i_rd_addr];
        r_tgt_q <= r_tgt_mem[i_rd_addr];
    end

    assign o_src_q = r_src_q;
    assign o_rep_q = r_rep_q;
    assign o_tgt_q = r_tgt_q;

endmodule

### hw/rtl/ctt_map_ram.sv
// Translation map memory: one write port for the builder, one registered read port.
module ctt_map_ram (
    input  logic             i_clk,
    input  ctt_pkg::t_map_wr i_wr,
    input  logic             i_rd_en,
    input  ctt_pkg::t_idx    i_rd_addr,
    output ctt_pkg::t_byte   o_rd_data
);
    import ctt_pkg::*;

    t_byte r_mem [SET_SIZE];
    t_byte r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/ctt_builder.sv
// Map build sequencer: walks every code and scans the target table with one shared comparator.
module ctt_builder (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  ctt_pkg::t_byte   i_default_char,
    input  ctt_pkg::t_ref    i_src_q,
    input  ctt_pkg::t_ref    i_rep_q,
    input  ctt_pkg::t_ref    i_tgt_q,
    output ctt_pkg::t_idx    o_rd_addr,
    output ctt_pkg::t_map_wr o_map_wr,
    output logic             o_busy,
    output logic             o_done
);
    import ctt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ZERO,
        S_FETCH,
        S_CHECK,
        S_SCAN,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    t_idx   r_code, n_code;
    t_idx   r_k, n_k;
    t_ref   r_key, n_key;
    t_ref   r_rep, n_rep;
    logic   r_pass, n_pass;

    t_ref    w_cmp_a;
    logic    w_eq;
    logic    w_adv;
    t_byte   w_fallback;
    t_idx    w_rd_addr;
    t_map_wr w_map_wr;

    // The one comparator: source against target while checking a code,
    // the search key against each target entry while scanning.
    assign w_cmp_a    = (r_state == S_CHECK) ? i_src_q : r_key;
    assign w_eq       = (i_tgt_q == w_cmp_a);
    assign w_fallback = (i_default_char != '0) ? i_default_char : BYTE_W'(r_code);

    always_comb begin
        n_state   = r_state;
        n_code    = r_code;
        n_k       = r_k;
        n_key     = r_key;
        n_rep     = r_rep;
        n_pass    = r_pass;
        w_rd_addr = r_code;
        w_map_wr  = '0;
        w_adv     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_ZERO;
                end
            end
            S_ZERO: begin
                w_map_wr.we = 1'b1;
                n_code      = t_idx'(1);
                n_state     = S_FETCH;
            end
            S_FETCH: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                w_map_wr.addr = r_code;
                if (w_eq) begin
                    w_map_wr.we   = 1'b1;
                    w_map_wr.data = BYTE_W'(r_code);
                    w_adv         = 1'b1;
                end else if (i_src_q == '0) begin
                    w_map_wr.we   = 1'b1;
                    w_map_wr.data = w_fallback;
                    w_adv         = 1'b1;
                end else begin
                    n_key     = i_src_q;
                    n_rep     = i_rep_q;
                    n_pass    = 1'b0;
                    n_k       = t_idx'(1);
                    w_rd_addr = t_idx'(1);
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                w_map_wr.addr = r_code;
                if (w_eq) begin
                    w_map_wr.we   = 1'b1;
                    w_map_wr.data = BYTE_W'(r_k);
                    w_adv         = 1'b1;
                end else if (r_k == LAST_IDX) begin
                    if (!r_pass && (r_rep != '0)) begin
                        n_key     = r_rep;
                        n_pass    = 1'b1;
                        n_k       = t_idx'(1);
                        w_rd_addr = t_idx'(1);
                    end else begin
                        w_map_wr.we   = 1'b1;
                        w_map_wr.data = w_fallback;
                        w_adv         = 1'b1;
                    end
                end else begin
                    n_k       = r_k + 1'b1;
                    w_rd_addr = r_k + 1'b1;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (w_adv) begin
            if (r_code == LAST_IDX) begin
                n_state = S_DONE;
            end else begin
                n_code    = r_code + 1'b1;
                w_rd_addr = r_code + 1'b1;
                n_state   = S_FETCH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
        r_code <= n_code;
        r_k    <= n_k;
        r_key  <= n_key;
        r_rep  <= n_rep;
    end

    assign o_rd_addr = w_rd_addr;
    assign o_map_wr  = w_map_wr;
    assign o_busy    = (r_state != S_IDLE);
    assign o_done    = (r_state == S_DONE);

`ifndef NO_ASSERTIONS
    a_scan_from_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_k != '0))
        else $error("target scan at index zero");
    a_second_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && r_pass |-> (r_key == r_rep) && (r_rep != '0))
        else $error("second search key is not the replacement code");
    a_done_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> $past(w_map_wr.we) && ($past(r_code) == LAST_IDX))
        else $error("build finished before the last code was written");
`endif

endmodule

### hw/rtl/charset_translation_table_unit.sv
// Top level of the byte character set translation table.
// A load item writes its table entry at acceptance, gives no result and leaves the input free.
// A convert item reads the map at acceptance; its result waits in the emit state for room
// in the output register, and the next item is taken once that state is left. A build
// visits codes 1 to SET_SIZE-1, each with up to two target scans on the one comparator.
// Synchronous active-low reset clears control state and default_char; tables need loading.
module charset_translation_table_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [ctt_pkg::FUNC_W-1:0]   i_func,
    input  logic [ctt_pkg::BYTE_W-1:0]   i_index,
    input  logic [ctt_pkg::REF_IN_W-1:0] i_ref_code,
    input  logic [ctt_pkg::BYTE_W-1:0]   i_byte_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [ctt_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                        o_build_done,
    input  logic                        i_cfg_we,
    input  logic [ctt_pkg::BYTE_W-1:0]   i_cfg_wdata
);
    import ctt_pkg::*;

    // The top sequencer: loads are finished on acceptance, a build hands
    // control to the builder, and every item with a result passes through
    // the emit state, which waits for room in the output register.
    typedef enum logic [1:0] {
        S_IDLE,
        S_BUILD,
        S_EMIT
    } t_state;

    t_state  r_state;
    t_byte   r_default_char;
    logic    r_res_build;
    logic    r_res_oob;
    logic    r_out_valid;
    t_byte   r_out_byte;
    logic    r_out_build;

    logic    w_accept;
    logic    w_in_range;
    logic    w_byte_range;
    logic    w_slot_free;
    logic    w_start;
    logic    w_conv;
    t_ld_req w_ld;
    t_idx    w_bld_addr;
    t_idx    w_rd_addr;
    t_map_wr w_map_wr;
    t_byte   w_map_q;
    t_ref    w_src_q;
    t_ref    w_rep_q;
    t_ref    w_tgt_q;
    logic    w_busy;
    logic    w_done;

    assign w_accept     = i_in_valid && (r_state == S_IDLE);
    assign w_in_range   = ({1'b0, i_index} < (BYTE_W + 1)'(SET_SIZE));
    assign w_byte_range = ({1'b0, i_byte_in} < (BYTE_W + 1)'(SET_SIZE));
    assign w_slot_free  = !r_out_valid || !i_out_stall;
    assign w_start      = w_accept && (i_func == FN_BUILD);
    assign w_conv       = w_accept && (i_func == FN_CONV);

    // Load items go straight into the tables; the stored code keeps its
    // low REF_BITS bits.
    always_comb begin
        w_ld        = '0;
        w_ld.addr   = t_idx'(i_index);
        w_ld.data   = REF_BITS'(i_ref_code);
        if (w_accept && w_in_range) begin
            case (i_func)
                FN_LD_SRC: w_ld.we_src = 1'b1;
                FN_LD_REP: w_ld.we_rep = 1'b1;
                FN_LD_TGT: w_ld.we_tgt = 1'b1;
                default:   w_ld.we_src = 1'b0;
            endcase
        end
    end

    // The builder owns the shared read address only while it runs.
    assign w_rd_addr = w_busy ? w_bld_addr : t_idx'(i_index);

    ctt_ref_tables u_tables (
        .i_clk     (i_clk),
        .i_ld      (w_ld),
        .i_rd_addr (w_rd_addr),
        .o_src_q   (w_src_q),
        .o_rep_q   (w_rep_q),
        .o_tgt_q   (w_tgt_q)
    );

    ctt_builder u_builder (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_start),
        .i_default_char (r_default_char),
        .i_src_q        (w_src_q),
        .i_rep_q        (w_rep_q),
        .i_tgt_q        (w_tgt_q),
        .o_rd_addr      (w_bld_addr),
        .o_map_wr       (w_map_wr),
        .o_busy         (w_busy),
        .o_done         (w_done)
    );

    ctt_map_ram u_map (
        .i_clk     (i_clk),
        .i_wr      (w_map_wr),
        .i_rd_en   (w_conv),
        .i_rd_addr (t_idx'(i_byte_in)),
        .o_rd_data (w_map_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_default_char <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_default_char <= i_cfg_wdata;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_start) begin
                        r_state <= S_BUILD;
                    end else if (w_conv) begin
                        r_state <= S_EMIT;
                    end
                end
                S_BUILD: begin
                    if (w_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_slot_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        if (w_accept) begin
            r_res_build <= (i_func == FN_BUILD);
            r_res_oob   <= !w_byte_range;
        end
        if ((r_state == S_EMIT) && w_slot_free) begin
            r_out_byte  <= (r_res_build || r_res_oob) ? '0 : w_map_q;
            r_out_build <= r_res_build;
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_build_done = r_out_build;

`ifndef NO_ASSERTIONS
    a_busy_in_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> (r_state == S_BUILD))
        else $error("builder running outside a build");
    a_build_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_build_done |-> (o_out_byte == '0))
        else $error("build acknowledgement carries a nonzero byte");
    a_emit_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte))
        else $error("pending result overwritten");
`endif

endmodule

### sim/tb.sv
// Self-checking testbench for the character set translation table unit.
module tb;
    import ctt_pkg::*;

    // Number of codes the function field can carry; codes past FN_CONV are unused.
    localparam int FUNC_CODES = 1 << FUNC_W;
    // Cycles allowed after the last result before the block counts as idle.
    localparam int SETTLE_CYCLES = 10;

    // One result as the block presents it.
    typedef struct packed {
        t_byte out_byte;
        logic  build_done;
    } t_reply;

    // Every input of the block has a known value from time zero on.
    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_in_valid   = 1'b0;
    logic                  o_in_stall;
    logic [FUNC_W-1:0]     i_func       = '0;
    logic [BYTE_W-1:0]     i_index      = '0;
    logic [REF_IN_W-1:0]   i_ref_code   = '0;
    logic [BYTE_W-1:0]     i_byte_in    = '0;
    logic                  o_out_valid;
    logic                  i_out_stall  = 1'b0;
    logic [BYTE_W-1:0]     o_out_byte;
    logic                  o_build_done;
    logic                  i_cfg_we     = 1'b0;
    logic [BYTE_W-1:0]     i_cfg_wdata  = '0;

    // Predictor state: the three reference code tables, the built map and the
    // default character, all updated in the order the block accepts items.
    t_ref  src_tab [SET_SIZE];
    t_ref  rep_tab [SET_SIZE];
    t_ref  tgt_tab [SET_SIZE];
    t_byte xlat_map [SET_SIZE];
    t_byte dflt_char = '0;

    // Results still owed by the block, oldest first.
    t_reply due_replies [$];
    int     fault_count = 0;

    // Idling controls shared between the stimulus and the stall driver.
    bit in_gaps_on      = 1'b1;
    bit out_gaps_on     = 1'b1;
    int out_hold_cycles = 0;

    charset_translation_table_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_index      (i_index),
        .i_ref_code   (i_ref_code),
        .i_byte_in    (i_byte_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_build_done (o_build_done),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    initial begin : clock_gen
        forever #5 i_clk = ~i_clk;
    end

    // First target index from 1 upward holding the given reference code, 0 if none.
    function automatic int first_target_hit(input t_ref code_ref);
        for (int k = 1; k < SET_SIZE; k++) begin
            if (tgt_tab[k] == code_ref) return k;
        end
        return 0;
    endfunction

    // Translation of one code whose source and target references differ.
    // A zero source reference is never searched for, and a zero replacement
    // reference skips the second search.
    function automatic t_byte translate_one(input int code);
        int hit;
        hit = 0;
        if (src_tab[code] != '0) begin
            hit = first_target_hit(src_tab[code]);
            if (hit == 0 && rep_tab[code] != '0) hit = first_target_hit(rep_tab[code]);
        end
        if (hit != 0) return t_byte'(hit);
        if (dflt_char != '0) return dflt_char;
        return t_byte'(code);
    endfunction

    // The map is computed from the tables and the default character as they
    // stand when the build item is accepted. Code 0 always maps to 0.
    function automatic void rebuild_xlat_map();
        xlat_map[0] = '0;
        for (int c = 1; c < SET_SIZE; c++) begin
            xlat_map[c] = (src_tab[c] == tgt_tab[c]) ? t_byte'(c) : translate_one(c);
        end
    endfunction

    // Applies one accepted item to the predictor and queues any result it owes.
    // Unused function codes change nothing and owe nothing.
    function automatic void account_for_item(input logic [FUNC_W-1:0] f, input t_byte idx,
                                             input logic [REF_IN_W-1:0] rc, input t_byte b);
        case (f)
            FN_LD_SRC: src_tab[idx] = t_ref'(rc);
            FN_LD_REP: rep_tab[idx] = t_ref'(rc);
            FN_LD_TGT: tgt_tab[idx] = t_ref'(rc);
            FN_BUILD: begin
                rebuild_xlat_map();
                due_replies.push_back(t_reply'{out_byte: '0, build_done: 1'b1});
            end
            FN_CONV: due_replies.push_back(t_reply'{out_byte: xlat_map[b], build_done: 1'b0});
            default: ;
        endcase
    endfunction

    // Reference codes are drawn mostly from a small pool so that searches hit
    // often. Source and replacement codes reach a little past the target pool,
    // which makes the first search miss and the replacement search matter.
    function automatic logic [REF_IN_W-1:0] pick_ref(input logic [FUNC_W-1:0] f);
        int roll;
        roll = $urandom_range(0, 15);
        if (roll == 0) return '0;
        if (roll == 1) return REF_IN_W'($urandom);
        if (f == FN_LD_TGT) return REF_IN_W'($urandom_range(1, 48));
        if (roll == 2) return '1;
        return REF_IN_W'($urandom_range(1, 64));
    endfunction

    // Offers one item and returns at the clock edge where it is accepted.
    // Valid is only lowered for an idle gap, so back-to-back items keep it high
    // without a second assignment in the same time step.
    task automatic offer_item(input logic [FUNC_W-1:0] f, input t_byte idx,
                              input logic [REF_IN_W-1:0] rc, input t_byte b);
        if (in_gaps_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= f;
        i_index    <= idx;
        i_ref_code <= rc;
        i_byte_in  <= b;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        account_for_item(f, idx, rc, b);
    endtask

    // Fields that the function does not use still carry random values.
    task automatic load_entry(input logic [FUNC_W-1:0] f, input t_byte idx,
                              input logic [REF_IN_W-1:0] rc);
        offer_item(f, idx, rc, t_byte'($urandom));
    endtask

    task automatic convert_byte(input t_byte b);
        offer_item(FN_CONV, t_byte'($urandom), REF_IN_W'($urandom), b);
    endtask

    task automatic request_build();
        offer_item(FN_BUILD, t_byte'($urandom), REF_IN_W'($urandom), t_byte'($urandom));
    endtask

    task automatic unused_func_item(input logic [FUNC_W-1:0] f);
        offer_item(f, t_byte'($urandom), REF_IN_W'($urandom), t_byte'($urandom));
    endtask

    // A random item of the steady traffic: mostly converts, some loads into a
    // random table, and now and then an unused function code.
    task automatic random_traffic_item();
        int pick;
        logic [FUNC_W-1:0] tf;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            convert_byte(t_byte'($urandom));
        end else if (pick < 95) begin
            case ($urandom_range(0, 2))
                0: tf = FN_LD_SRC;
                1: tf = FN_LD_REP;
                default: tf = FN_LD_TGT;
            endcase
            load_entry(tf, t_byte'($urandom), pick_ref(tf));
        end else begin
            unused_func_item(FUNC_W'($urandom_range(int'(FN_CONV) + 1, FUNC_CODES - 1)));
        end
    endtask

    // Stops offering, waits for every owed result, then lets loads and any
    // trailing work finish before the block is treated as idle.
    task automatic quiesce();
        i_in_valid <= 1'b0;
        while (due_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // The register takes the value at the edge where the write enable is high.
    task automatic write_default_char(input t_byte value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        dflt_char = value;
    endtask

    // Every entry of all three tables is written before the first build, so
    // no build ever reads an entry that was never loaded.
    task automatic test_table_fill();
        write_default_char('0);
        for (int idx = 0; idx < SET_SIZE; idx++) begin
            load_entry(FN_LD_SRC, t_byte'(idx), pick_ref(FN_LD_SRC));
            load_entry(FN_LD_REP, t_byte'(idx), pick_ref(FN_LD_REP));
            load_entry(FN_LD_TGT, t_byte'(idx), pick_ref(FN_LD_TGT));
        end
    endtask

    // Hand-placed entries for each path through the translation of one code.
    task automatic test_special_codes();
        // Target entry 0 is never searched: code 5 looks for a reference that
        // only index 0 holds, and its zero replacement skips the second search.
        load_entry(FN_LD_TGT, 8'd0, 16'hBEEF);
        load_entry(FN_LD_SRC, 8'd5, 16'hBEEF);
        load_entry(FN_LD_REP, 8'd5, 16'h0000);
        // Code 0 maps to 0 whatever its source entry says.
        load_entry(FN_LD_SRC, 8'd0, 16'h0007);
        // A match at the highest index, with the widest reference code.
        load_entry(FN_LD_TGT, 8'd255, 16'hFFFF);
        load_entry(FN_LD_SRC, 8'd1, 16'hFFFF);
        // Equal zero references map a code to itself.
        load_entry(FN_LD_SRC, 8'd2, 16'h0000);
        load_entry(FN_LD_TGT, 8'd2, 16'h0000);
        // A zero source reference next to a nonzero target falls to the default.
        load_entry(FN_LD_SRC, 8'd3, 16'h0000);
        load_entry(FN_LD_TGT, 8'd3, 16'h0005);
        // The first search misses and the replacement reference is found.
        load_entry(FN_LD_SRC, 8'd4, 16'hA5A5);
        load_entry(FN_LD_REP, 8'd4, 16'h1234);
        load_entry(FN_LD_TGT, 8'd200, 16'h1234);
        // Unused function codes must not write anything.
        for (int f = int'(FN_CONV) + 1; f < FUNC_CODES; f++) begin
            offer_item(FUNC_W'(f), 8'd4, 16'h5A5A, 8'd4);
        end
        request_build();
        convert_byte(8'd0);
        convert_byte(8'd1);
        convert_byte(8'd2);
        convert_byte(8'd3);
        convert_byte(8'd4);
        convert_byte(8'd5);
        convert_byte(8'd255);
    endtask

    // The default character only takes effect at the next build.
    task automatic test_default_char_extremes();
        quiesce();
        write_default_char('1);
        convert_byte(8'd3);
        convert_byte(8'd5);
        request_build();
        convert_byte(8'd3);
        convert_byte(8'd5);
    endtask

    // Rounds of mixed traffic, each under its own default character and each
    // with one build at a random point, so loads land both before and after it.
    task automatic test_random_traffic();
        int build_at;
        t_byte setting;
        for (int round = 0; round < 4; round++) begin
            case (round)
                1: setting = '0;
                2: setting = '1;
                default: setting = t_byte'($urandom_range(1, 254));
            endcase
            quiesce();
            write_default_char(setting);
            build_at = $urandom_range(5, 20);
            for (int n = 0; n < 25; n++) begin
                if (n == build_at) request_build();
                else random_traffic_item();
            end
        end
    endtask

    // The result side holds off for a long stretch while converts keep coming,
    // so the block fills up and has to stall its input.
    task automatic test_output_backpressure();
        quiesce();
        out_hold_cycles = 200;
        repeat (20) convert_byte(t_byte'($urandom));
        quiesce();
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_no_idle_tail();
        in_gaps_on  = 1'b0;
        out_gaps_on = 1'b0;
        repeat (30) random_traffic_item();
    endtask

    // Drives the result stall: a long hold when one is requested, otherwise
    // random bursts while idling is enabled.
    initial begin : result_stall_driver
        int burst;
        forever begin
            @(posedge i_clk);
            if (out_hold_cycles > 0) begin
                burst = out_hold_cycles;
                out_hold_cycles = 0;
                i_out_stall <= 1'b1;
                repeat (burst) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (out_gaps_on && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Compares each accepted result with the oldest owed one. Values are read
    // at the clock edge, before the block updates its outputs.
    initial begin : result_checker
        t_reply want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (due_replies.size() == 0) begin
                    $error("result with nothing owed: out_byte %0d, build_done %0d",
                           o_out_byte, o_build_done);
                    fault_count++;
                end else begin
                    want = due_replies.pop_front();
                    if (o_out_byte !== want.out_byte) begin
                        $error("out_byte mismatch: expected %0d, actual %0d",
                               want.out_byte, o_out_byte);
                        fault_count++;
                    end
                    if (o_build_done !== want.build_done) begin
                        $error("build_done mismatch: expected %0d, actual %0d",
                               want.build_done, o_build_done);
                        fault_count++;
                    end
                end
            end
        end
    end

    // The run has six builds, each of which may scan the target table twice per code,
    // so this bound leaves several times the slowest correct run.
    initial begin : watchdog
        #50_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_table_fill();
        test_special_codes();
        test_default_char_extremes();
        test_random_traffic();
        test_output_backpressure();
        test_no_idle_tail();
        quiesce();
        if (fault_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
